// ===== rtl/kuf_pkg.sv =====
// Shared types, sizes and codes for the union-find edge filter.
`default_nettype none

package kuf_pkg;

  // Size of the union-find store and derived widths.
  localparam int unsigned MAX_CELLS = 4096;
  localparam int unsigned CELL_W    = $clog2(MAX_CELLS);
  localparam int unsigned TOTAL_W   = CELL_W + 1;

  // Fixed field widths.
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned RANK_W = 4;
  localparam int unsigned RANK_MAX = (1 << RANK_W) - 1;
  localparam int unsigned CNT_MAX  = (1 << CNT_W) - 1;

  // Width that holds any cell index sum and the cell limit itself.
  localparam int unsigned IDX_W = POS_W + 1 + CFG_W + 1;
  localparam int unsigned SUM_W = (IDX_W > TOTAL_W) ? IDX_W : TOTAL_W;
  localparam int unsigned SAT_W = (CELL_W > CNT_W) ? CELL_W : CNT_W;

  // Queue between the classifier and the union-find engine.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_GRID_WIDTH  = 1'b0;
  localparam logic        REG_GRID_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

  // Grid configuration as seen by the front and back parts.
  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } cfg_t;

  // One classified edge word.
  typedef struct packed {
    logic [CELL_W-1:0] cell_a;
    logic [CELL_W-1:0] cell_b;
    logic              off_grid;
  } edge_t;

  // One entry of the union-find store.
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [CELL_W-1:0] parent;
  } uf_word_t;

  localparam int unsigned UF_W = RANK_W + CELL_W;

  // Status of the back part as seen by the top level.
  typedef struct packed {
    logic clearing;
  } back_status_t;

  // Joined-edge count limited to the width of the result field.
  function automatic logic [CNT_W-1:0] sat_count(input logic [CELL_W-1:0] count);
    logic [SAT_W-1:0] ext;
    ext = SAT_W'(count);
    if (ext > SAT_W'(CNT_MAX)) begin
      return CNT_W'(CNT_MAX);
    end
    return CNT_W'(ext);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kuf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module kuf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port; a read of the same address in that cycle returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/kuf_fifo.sv =====
// Short word queue between the edge classifier and the union-find engine.
`default_nettype none

module kuf_fifo import kuf_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  edge_t data_i,
  output logic  full_o,
  input  wire   pop_i,
  output logic  empty_o,
  output edge_t data_o
);

  edge_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_PTR_W:0]   count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage of the queued words.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kuf_front.sv =====
// Front part: takes wall edges, forms both cell indices and flags off-grid edges.
`default_nettype none

module kuf_front import kuf_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  cfg_t             cfg_i,
  input  wire              clearing_i,
  input  wire              push_i,
  output logic             full_o,
  input  wire [POS_W-1:0]  cell_row_i,
  input  wire [POS_W-1:0]  cell_col_i,
  input  wire              wall_dir_i,
  output logic             edge_push_o,
  output edge_t            edge_o,
  input  wire              edge_full_i
);

  logic             valid_q;
  logic [POS_W-1:0] row_q, col_q;
  logic             dir_q;
  logic             take;
  logic [SUM_W-1:0] r1, c1, r2, c2, w, h, a, b, lim;
  logic             outside;

  // The stage holds one raw edge; it frees up once the queue takes the word.
  assign full_o      = (valid_q && edge_full_i) || clearing_i;
  assign take        = push_i && !full_o;
  assign edge_push_o = valid_q && !edge_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (edge_push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      row_q <= cell_row_i;
      col_q <= cell_col_i;
      dir_q <= wall_dir_i;
    end
  end

  // Cell numbering row*width+col for both cells, and the grid bounds check.
  always_comb begin
    r1  = SUM_W'(row_q);
    c1  = SUM_W'(col_q);
    w   = SUM_W'(cfg_i.width);
    h   = SUM_W'(cfg_i.height);
    lim = SUM_W'(MAX_CELLS);
    r2  = r1 + SUM_W'(dir_q);
    c2  = c1 + SUM_W'(!dir_q);
    a   = r1 * w + c1;
    b   = a + (dir_q ? w : SUM_W'(1));
    outside = (r2 >= h) || (c2 >= w) || (a >= lim) || (b >= lim);
    edge_o.cell_a   = a[CELL_W-1:0];
    edge_o.cell_b   = b[CELL_W-1:0];
    edge_o.off_grid = outside;
  end

endmodule

`default_nettype wire

// ===== rtl/kuf_back.sv =====
// Back part: union-find engine with path compression and union by rank.
`default_nettype none

module kuf_back import kuf_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  cfg_t              cfg_i,
  output back_status_t      status_o,
  input  wire               edge_empty_i,
  input  edge_t             edge_i,
  output logic              edge_pop_o,
  input  wire               pop_i,
  output logic              empty_o,
  output logic              carve_o,
  output logic              off_grid_o,
  output logic [CNT_W-1:0]  edges_joined_o,
  output logic              tree_done_o
);

  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_CLEAR  = 3'd0;
  localparam logic [ST_W-1:0] ST_IDLE   = 3'd1;
  localparam logic [ST_W-1:0] ST_WALK   = 3'd2;
  localparam logic [ST_W-1:0] ST_COMP   = 3'd3;
  localparam logic [ST_W-1:0] ST_MERGE  = 3'd4;
  localparam logic [ST_W-1:0] ST_RANK   = 3'd5;
  localparam logic [ST_W-1:0] ST_RESULT = 3'd6;

  logic [ST_W-1:0]   state_q, state_d;
  logic [CELL_W-1:0] clr_idx_q, clr_idx_d;
  logic [CELL_W-1:0] joined_q, joined_d;
  logic              out_valid_q, out_valid_d;

  logic [CELL_W-1:0] cur_q, cur_d, start_q, start_d, b_q, b_d;
  logic [CELL_W-1:0] root_q, root_d, root_a_q, root_a_d, hi_q, hi_d;
  logic [RANK_W-1:0] root_rank_q, root_rank_d, rank_a_q, rank_a_d;
  logic [RANK_W-1:0] hi_rank_q, hi_rank_d;
  logic              phase_q, phase_d, carve_q, carve_d, off_q, off_d;
  logic [TOTAL_W-1:0] cells_q;

  logic              out_carve_q, out_off_q, out_done_q;
  logic [CNT_W-1:0]  out_joined_q;
  logic              load_out;

  logic              ram_we;
  logic [CELL_W-1:0] ram_waddr, ram_raddr;
  uf_word_t          ram_wdata, ram_rdata;
  logic [UF_W-1:0]   ram_rdata_raw;

  logic [SUM_W-1:0]  grid_cells;
  logic              tree_done;
  logic              slot_free;
  logic              a_wins;
  logic [CELL_W-1:0] lo_node;
  logic [RANK_W-1:0] lo_rank, win_rank;

  kuf_ram #(
    .WIDTH (UF_W),
    .DEPTH (MAX_CELLS)
  ) u_uf_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = uf_word_t'(ram_rdata_raw);

  // Cell count of the grid, limited to the store size.
  assign grid_cells = SUM_W'(cfg_i.width) * SUM_W'(cfg_i.height);

  always_ff @(posedge clk_i) begin
    cells_q <= (grid_cells >= SUM_W'(MAX_CELLS)) ? TOTAL_W'(MAX_CELLS)
                                                 : TOTAL_W'(grid_cells);
  end

  assign tree_done = (cells_q != '0) &&
                     ((TOTAL_W'(joined_q) + TOTAL_W'(1)) >= cells_q);

  assign slot_free = !out_valid_q || pop_i;
  assign status_o.clearing = (state_q == ST_CLEAR);

  // Winner of a merge: the root of higher rank, the first root on a tie.
  assign a_wins   = !(rank_a_q < root_rank_q);
  assign lo_node  = a_wins ? root_q : root_a_q;
  assign lo_rank  = a_wins ? root_rank_q : rank_a_q;
  assign win_rank = a_wins ? rank_a_q : root_rank_q;

  // Sequencer: clearing pass, two root finds with compression, merge, result.
  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    joined_d    = joined_q;
    cur_d       = cur_q;
    start_d     = start_q;
    b_d         = b_q;
    root_d      = root_q;
    root_rank_d = root_rank_q;
    root_a_d    = root_a_q;
    rank_a_d    = rank_a_q;
    hi_d        = hi_q;
    hi_rank_d   = hi_rank_q;
    phase_d     = phase_q;
    carve_d     = carve_q;
    off_d       = off_q;
    edge_pop_o  = 1'b0;
    load_out    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cur_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = cur_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        ram_wdata = '{rank: '0, parent: clr_idx_q};
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == CELL_W'(MAX_CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!edge_empty_i) begin
          edge_pop_o = 1'b1;
          off_d      = edge_i.off_grid;
          carve_d    = 1'b0;
          if (edge_i.off_grid || tree_done) begin
            state_d = ST_RESULT;
          end else begin
            ram_raddr = edge_i.cell_a;
            cur_d     = edge_i.cell_a;
            start_d   = edge_i.cell_a;
            b_d       = edge_i.cell_b;
            phase_d   = 1'b0;
            state_d   = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // Read data belongs to cur_q; follow parents up to the root.
        if (ram_rdata.parent == cur_q) begin
          root_d      = cur_q;
          root_rank_d = ram_rdata.rank;
          cur_d       = start_q;
          ram_raddr   = start_q;
          state_d     = ST_COMP;
        end else begin
          cur_d     = ram_rdata.parent;
          ram_raddr = ram_rdata.parent;
        end
      end
      ST_COMP: begin
        if (cur_q == root_q) begin
          if (!phase_q) begin
            root_a_d  = root_q;
            rank_a_d  = root_rank_q;
            phase_d   = 1'b1;
            cur_d     = b_q;
            start_d   = b_q;
            ram_raddr = b_q;
            state_d   = ST_WALK;
          end else if (root_q == root_a_q) begin
            state_d = ST_RESULT;
          end else begin
            state_d = ST_MERGE;
          end
        end else begin
          // Point this path node straight at the root and step to its parent.
          ram_we    = 1'b1;
          ram_waddr = cur_q;
          ram_wdata = '{rank: ram_rdata.rank, parent: root_q};
          cur_d     = ram_rdata.parent;
          ram_raddr = ram_rdata.parent;
        end
      end
      ST_MERGE: begin
        ram_we    = 1'b1;
        ram_waddr = lo_node;
        ram_wdata = '{rank: lo_rank, parent: (a_wins ? root_a_q : root_q)};
        joined_d  = joined_q + 1'b1;
        carve_d   = 1'b1;
        hi_d      = a_wins ? root_a_q : root_q;
        hi_rank_d = win_rank + 1'b1;
        if ((rank_a_q == root_rank_q) && (win_rank < RANK_W'(RANK_MAX))) begin
          state_d = ST_RANK;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_RANK: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q;
        ram_wdata = '{rank: hi_rank_q, parent: hi_q};
        state_d   = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      joined_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      joined_q    <= joined_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers of the current edge.
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    start_q     <= start_d;
    b_q         <= b_d;
    root_q      <= root_d;
    root_rank_q <= root_rank_d;
    root_a_q    <= root_a_d;
    rank_a_q    <= rank_a_d;
    hi_q        <= hi_d;
    hi_rank_q   <= hi_rank_d;
    phase_q     <= phase_d;
    carve_q     <= carve_d;
    off_q       <= off_d;
  end

  // Result word, held until it is taken.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_carve_q  <= carve_q;
      out_off_q    <= off_q;
      out_joined_q <= sat_count(joined_q);
      out_done_q   <= tree_done;
    end
  end

  assign empty_o        = !out_valid_q;
  assign carve_o        = out_carve_q;
  assign off_grid_o     = out_off_q;
  assign edges_joined_o = out_joined_q;
  assign tree_done_o    = out_done_q;

  // Sets are merged only when the two roots really differ.
  a_merge_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE) |-> (root_q != root_a_q))
    else $error("merge started with equal roots");

  // Compression never rewrites the root entry itself.
  a_comp_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP && ram_we) |-> (ram_waddr != root_q))
    else $error("compression write hit the root");

  // The joined count only ever grows by one, on a merge.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_MERGE) |=> (joined_q == $past(joined_q)))
    else $error("joined count changed outside a merge");

endmodule

`default_nettype wire

// ===== rtl/kruskal_union_find_edge_filter.sv =====
// Top level of the Kruskal spanning-tree edge filter with its configuration port.
`default_nettype none

// Wall edges enter through a queue-style port (push/full) and each edge gives
// one result word (pop/empty): carve, off_grid, the joined-edge count and the
// tree-done flag. After reset the union-find store is cleared in a pass over
// all 4096 entries, one entry a cycle, during which full stays high;
// configuration writes are taken throughout. An edge that is off the grid, or
// arrives once the tree is complete, goes from idle straight to the result
// state of the union-find engine. An edge whose two cells already share a set
// passes through two root finds, each with its path-compression pass, then
// the result state; a carved edge also passes the merge state, and the rank
// state when the merge raises a rank. Both root finds and their compression
// passes share the single read port and single write port of the store, one
// chain step a cycle. A four-word queue between the classifier and the engine
// lets new edges be taken while one is in work.
module kruskal_union_find_edge_filter import kuf_pkg::*; (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire [APB_ADDR_W-1:0]  paddr,
  input  wire [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  wire                   push,
  output logic                  full,
  input  wire [POS_W-1:0]       cell_row_i,
  input  wire [POS_W-1:0]       cell_col_i,
  input  wire                   wall_dir_i,
  output logic                  empty,
  input  wire                   pop,
  output logic                  carve_o,
  output logic                  off_grid_o,
  output logic [CNT_W-1:0]      edges_joined_o,
  output logic                  tree_done_o
);

  cfg_t         cfg_q;
  logic         cfg_write;
  logic         reg_sel;
  back_status_t back_status;
  logic         edge_push, edge_full, edge_pop, edge_empty;
  edge_t        edge_in, edge_out;

  // Configuration registers; register index comes from address bit two.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= GRID_RESET;
      cfg_q.height <= GRID_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_GRID_WIDTH:  cfg_q.width  <= pwdata[CFG_W-1:0];
        REG_GRID_HEIGHT: cfg_q.height <= pwdata[CFG_W-1:0];
        default:         cfg_q        <= cfg_q;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      REG_GRID_WIDTH:  prdata = APB_DATA_W'(cfg_q.width);
      REG_GRID_HEIGHT: prdata = APB_DATA_W'(cfg_q.height);
      default:         prdata = '0;
    endcase
  end

  kuf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clearing_i  (back_status.clearing),
    .push_i      (push),
    .full_o      (full),
    .cell_row_i  (cell_row_i),
    .cell_col_i  (cell_col_i),
    .wall_dir_i  (wall_dir_i),
    .edge_push_o (edge_push),
    .edge_o      (edge_in),
    .edge_full_i (edge_full)
  );

  kuf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (edge_push),
    .data_i  (edge_in),
    .full_o  (edge_full),
    .pop_i   (edge_pop),
    .empty_o (edge_empty),
    .data_o  (edge_out)
  );

  kuf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .status_o       (back_status),
    .edge_empty_i   (edge_empty),
    .edge_i         (edge_out),
    .edge_pop_o     (edge_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .carve_o        (carve_o),
    .off_grid_o     (off_grid_o),
    .edges_joined_o (edges_joined_o),
    .tree_done_o    (tree_done_o)
  );

endmodule

`default_nettype wire
